/* sv/tpfr_pkg.sv */
// shared constants and types of the telemetry poll frame receiver
// used by every module of the block; depends on nothing
`default_nettype none

package tpfr_pkg;

	localparam int unsigned PAYLOAD_BYTES = 7;
	localparam int unsigned CNT_W = $clog2(PAYLOAD_BYTES + 1);
	localparam int unsigned IDX_W = $clog2(PAYLOAD_BYTES);
	localparam int unsigned SUM_W = 16;

	localparam logic [7:0] START_BYTE = 8'h7E;
	localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
	localparam logic [7:0] ESCAPE_XOR = 8'h20;
	localparam logic [SUM_W-1:0] SUM_GOOD = 16'h00FF;

	// configuration register indexes
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_OWN_ID = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PEER_ID = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CSUM_EN = 2'd2;

	localparam logic [7:0] OWN_ID_RST = 8'd27;
	localparam logic [7:0] PEER_ID_RST = 8'd13;
	localparam logic CSUM_EN_RST = 1'b1;

	typedef struct packed {
		logic hunting;
		logic expect_id;
		logic escape_pending;
		logic [CNT_W-1:0] byte_count;
		logic [SUM_W-1:0] running_sum;
	} rx_state_t;

	typedef struct packed {
		logic [7:0] own_id;
		logic [7:0] peer_id;
		logic csum_en;
	} rx_cfg_t;

	typedef struct packed {
		logic we;
		logic [IDX_W-1:0] idx;
		logic [7:0] data;
	} store_wr_t;

	typedef struct packed {
		logic cts_clear;
		logic cts_set;
		logic emit;
	} rx_event_t;

	localparam rx_state_t STATE_RST = '{
		hunting: 1'b1,
		expect_id: 1'b0,
		escape_pending: 1'b0,
		byte_count: '0,
		running_sum: '0
	};

endpackage

`default_nettype wire

/* sv/tpfr_byte_decoder.sv */
// per-byte decode: resync, sensor id match, unstuffing, sum and frame completion
// combinational; depends on tpfr_pkg
`default_nettype none

module tpfr_byte_decoder (
	input  wire logic [7:0]          line_byte,
	input  wire logic                host_ready,
	input  wire tpfr_pkg::rx_cfg_t   cfg,
	input  wire tpfr_pkg::rx_state_t cur,
	output tpfr_pkg::rx_state_t      nxt,
	output tpfr_pkg::store_wr_t      wr,
	output tpfr_pkg::rx_event_t      evt
);
	import tpfr_pkg::*;

	logic [7:0] c;
	logic [CNT_W-1:0] cnt_inc;
	logic [SUM_W-1:0] sum_add;
	logic [SUM_W-1:0] sum_fold;

	assign c = cur.escape_pending ? (line_byte ^ ESCAPE_XOR) : line_byte;
	assign cnt_inc = cur.byte_count + CNT_W'(1);
	assign sum_add = cur.running_sum + SUM_W'(c);
	assign sum_fold = SUM_W'(sum_add[7:0]) + SUM_W'(sum_add[SUM_W-1:8]);

	always_comb begin
		nxt = cur;
		wr.we = 1'b0;
		wr.idx = cur.byte_count[IDX_W-1:0];
		wr.data = c;
		evt = '0;
		if (line_byte == START_BYTE) begin
			evt.cts_clear = 1'b1;
			nxt.byte_count = '0;
			nxt.expect_id = 1'b1;
			nxt.hunting = 1'b0;
			nxt.escape_pending = 1'b0;
		end else if (!cur.hunting) begin
			if (cur.expect_id) begin
				nxt.expect_id = 1'b0;
				if (line_byte == cfg.own_id && host_ready) begin
					evt.cts_set = 1'b1;
					nxt.hunting = 1'b1;
				end else if (line_byte == cfg.peer_id) begin
					nxt.running_sum = '0;
				end else begin
					nxt.hunting = 1'b1;
				end
			end else if (line_byte == ESCAPE_BYTE) begin
				nxt.escape_pending = 1'b1;
			end else begin
				nxt.escape_pending = 1'b0;
				if (cur.byte_count < CNT_W'(PAYLOAD_BYTES)) begin
					wr.we = 1'b1;
					nxt.byte_count = cnt_inc;
					nxt.running_sum = sum_add;
					if (!cfg.csum_en && cnt_inc == CNT_W'(PAYLOAD_BYTES)) begin
						nxt.hunting = 1'b1;
						evt.emit = 1'b1;
					end
				end else begin
					// trailing checksum byte
					nxt.hunting = 1'b1;
					nxt.running_sum = sum_fold;
					evt.emit = (sum_fold == SUM_GOOD);
				end
			end
		end
	end

endmodule

`default_nettype wire

/* sv/tpfr_frame_store.sv */
// payload byte store with write-through view for the byte being written
// depends on tpfr_pkg
`default_nettype none

module tpfr_frame_store (
	input  wire logic                clk,
	input  wire logic                load,
	input  wire tpfr_pkg::store_wr_t wr,
	output logic [tpfr_pkg::PAYLOAD_BYTES*8-1:0] view
);
	import tpfr_pkg::*;

	logic [7:0] bytes_q [PAYLOAD_BYTES];

	always_ff @(posedge clk) begin
		if (load && wr.we) begin
			bytes_q[wr.idx] <= wr.data;
		end
	end

	always_comb begin
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			if (wr.we && wr.idx == IDX_W'(i)) begin
				view[i*8 +: 8] = wr.data;
			end else begin
				view[i*8 +: 8] = bytes_q[i];
			end
		end
	end

endmodule

`default_nettype wire

/* sv/telemetry_poll_frame_receiver_core.sv */
// top level of the telemetry poll frame receiver: input stage, decode, result register
// depends on tpfr_pkg, tpfr_byte_decoder and tpfr_frame_store
//
// channel  | dir | tdata bits (lowest first)                         | tuser
// s_axis   | in  | line_byte[7:0], host_ready[8], pad to 16           | -
// m_axis   | out | cts_clear[0], cts_set[1], frame_kind[9:2],         | frame_valid
//          |     | value_ident[25:10], value_word[57:26], pad to 64   |
// cfg      | in  | wr_en, wr_index (0 own id, 1 peer id, 2 csum en), wr_data
//
// one word in, one word out; sustained rate one word per cycle while m_tready stays high
// data path: input register, then decode into the result register
// arst_n clears the receiver to hunting for a start byte and loads register defaults
// a stalled result holds the result register; the input stage still takes one word,
// and s_tready drops only while both stages are full
`default_nettype none

module telemetry_poll_frame_receiver_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // line_byte, host_ready
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // cts_clear, cts_set, frame_kind, value_ident, value_word
	output logic             m_tuser,   // frame_valid
	input  wire logic        wr_en,
	input  wire logic [tpfr_pkg::REG_IDX_W-1:0] wr_index,
	input  wire logic [7:0]  wr_data
);
	import tpfr_pkg::*;

	// configuration registers
	rx_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_id <= OWN_ID_RST;
			cfg_q.peer_id <= PEER_ID_RST;
			cfg_q.csum_en <= CSUM_EN_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_OWN_ID: cfg_q.own_id <= wr_data;
				REG_PEER_ID: cfg_q.peer_id <= wr_data;
				REG_CSUM_EN: cfg_q.csum_en <= wr_data[0];
				default: ; // unknown index, write dropped
			endcase
		end
	end

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       ready_s1;
	logic       load;

	// the result register takes the staged word when it is empty or being drained
	assign load = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
			ready_s1 <= s_tdata[8];
		end
	end

	// receiver state, advanced once per decoded word
	rx_state_t state_q;
	rx_state_t state_nxt;
	store_wr_t store_wr;
	rx_event_t evt;
	logic [PAYLOAD_BYTES*8-1:0] frame_view;

	tpfr_byte_decoder u_dec (
		.line_byte  (byte_s1),
		.host_ready (ready_s1),
		.cfg        (cfg_q),
		.cur        (state_q),
		.nxt        (state_nxt),
		.wr         (store_wr),
		.evt        (evt)
	);

	tpfr_frame_store u_store (
		.clk  (clk),
		.load (load),
		.wr   (store_wr),
		.view (frame_view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
		end else if (load) begin
			state_q <= state_nxt;
		end
	end

	// result register; frame fields read zero unless a frame is delivered
	logic [63:0] result_data;

	always_comb begin
		result_data = '0;
		result_data[0] = evt.cts_clear;
		result_data[1] = evt.cts_set;
		if (evt.emit) begin
			result_data[57:2] = frame_view;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= result_data;
			m_tuser <= evt.emit;
		end
	end

`ifndef SYNTHESIS
	// no frame fields without a delivered frame
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[57:2] == '0)
		else $error("frame fields set without frame_valid");

	// a delivered frame, a start byte and our slot are mutually exclusive
	a_events_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones({m_tdata[0], m_tdata[1], m_tuser}) <= 1)
		else $error("conflicting events in one result word");

	// after a frame is delivered the receiver hunts for the next start byte
	a_hunt_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		load && evt.emit |=> state_q.hunting)
		else $error("receiver not hunting after frame");

	// a staged word is never dropped while the result side stalls
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load |=> valid_s1 && $stable(byte_s1))
		else $error("staged word lost during stall");
`endif

endmodule

`default_nettype wire

/* tb/telemetry_poll_frame_receiver_core_tb.sv */
`timescale 1ns / 1ps
// testbench of telemetry_poll_frame_receiver_core: directed and random line bytes,
// every result checked against a local decoder model; depends on tpfr_pkg and the core

module telemetry_poll_frame_receiver_core_tb;

	import tpfr_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum {TRAILER_NONE, TRAILER_GOOD, TRAILER_BAD} trailer_t;

	typedef struct packed {
		logic cts_clear;
		logic cts_set;
		logic frame_valid;
		logic [7:0] frame_kind;
		logic [15:0] value_ident;
		logic [31:0] value_word;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic m_tuser;
	logic wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [7:0] wr_data = '0;

	// decoder model state, starts at the reset values
	logic [7:0] cfg_own_id = OWN_ID_RST;
	logic [7:0] cfg_peer_id = PEER_ID_RST;
	logic cfg_csum_en = CSUM_EN_RST;
	logic rx_hunting = 1'b1;
	logic rx_expect_id = 1'b0;
	logic rx_escape = 1'b0;
	logic [2:0] rx_count = '0;
	logic [15:0] rx_sum = '0;
	logic [7:0] rx_store [PAYLOAD_BYTES] = '{default: 8'h00};

	frame_result_t pending_results[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int words_sent = 0;
	int results_checked = 0;
	int frames_predicted = 0;
	int slots_predicted = 0;
	int reg_writes = 0;
	int error_count = 0;

	telemetry_poll_frame_receiver_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one line byte through the decoder model, returns the result word it causes
	function automatic frame_result_t decode_line_byte(input logic [7:0] raw, input logic ready);
		frame_result_t r;
		logic [7:0] c;
		logic emit;
		r = '0;
		c = raw;
		emit = 1'b0;
		if (c == START_BYTE) begin
			// start byte always resyncs, also mid-frame and after an escape
			r.cts_clear = 1'b1;
			rx_count = '0;
			rx_expect_id = 1'b1;
			rx_hunting = 1'b0;
			rx_escape = 1'b0;
		end else if (!rx_hunting) begin
			if (rx_expect_id) begin
				// id byte is taken raw, our slot wins over the peer when ready
				rx_expect_id = 1'b0;
				if (c == cfg_own_id && ready) begin
					r.cts_set = 1'b1;
					rx_hunting = 1'b1;
				end else if (c == cfg_peer_id)
					rx_sum = '0;
				else
					rx_hunting = 1'b1;
			end else if (c == ESCAPE_BYTE)
				rx_escape = 1'b1;
			else begin
				if (rx_escape) begin
					c = c ^ ESCAPE_XOR;
					rx_escape = 1'b0;
				end
				if (rx_count < 3'(PAYLOAD_BYTES)) begin
					rx_store[rx_count] = c;
					rx_count = rx_count + 3'd1;
					rx_sum = rx_sum + 16'(c);
					if (!cfg_csum_en && rx_count == 3'(PAYLOAD_BYTES)) begin
						rx_hunting = 1'b1;
						emit = 1'b1;
					end
				end else begin
					// checksum byte: add, fold once, compare
					rx_hunting = 1'b1;
					rx_sum = rx_sum + 16'(c);
					rx_sum = {8'h00, rx_sum[7:0]} + {8'h00, rx_sum[15:8]};
					emit = (rx_sum == SUM_GOOD);
				end
			end
		end
		if (emit) begin
			r.frame_valid = 1'b1;
			r.frame_kind = rx_store[0];
			r.value_ident = {rx_store[2], rx_store[1]};
			r.value_word = {rx_store[6], rx_store[5], rx_store[4], rx_store[3]};
			frames_predicted++;
		end
		if (r.cts_set)
			slots_predicted++;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		$display("mismatch at %0t, result %0d, %s: got %h want %h",
			$realtime, results_checked, what, got, want);
	endtask

	// receiver side stalls
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// result checker, oldest expectation first
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0)
				report_mismatch("word with nothing expected", m_tdata, '0);
			else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.cts_clear)
					report_mismatch("cts_clear", 64'(m_tdata[0]), 64'(want.cts_clear));
				if (m_tdata[1] !== want.cts_set)
					report_mismatch("cts_set", 64'(m_tdata[1]), 64'(want.cts_set));
				if (m_tuser !== want.frame_valid)
					report_mismatch("frame_valid", 64'(m_tuser), 64'(want.frame_valid));
				if (m_tdata[9:2] !== want.frame_kind)
					report_mismatch("frame_kind", 64'(m_tdata[9:2]),
						64'(want.frame_kind));
				if (m_tdata[25:10] !== want.value_ident)
					report_mismatch("value_ident", 64'(m_tdata[25:10]),
						64'(want.value_ident));
				if (m_tdata[57:26] !== want.value_word)
					report_mismatch("value_word", 64'(m_tdata[57:26]),
						64'(want.value_word));
				if (m_tdata[63:58] !== 6'd0)
					report_mismatch("tdata pad", 64'(m_tdata[63:58]), '0);
			end
			results_checked++;
		end
	end

	// one word on the input side, called and returning at a falling edge
	task automatic send_word(input logic [7:0] line_byte, input logic ready);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 16'($urandom_range(511));
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, ready, line_byte};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(decode_line_byte(line_byte, ready));
		words_sent++;
		@(negedge clk);
	endtask

	// byte stuffing: start and escape values always escaped, others now and then
	task automatic send_stuffed(input logic [7:0] value, input int esc_pct);
		logic [7:0] flipped;
		flipped = value ^ ESCAPE_XOR;
		if (value == START_BYTE || value == ESCAPE_BYTE ||
				(flipped != START_BYTE && flipped != ESCAPE_BYTE &&
				$urandom_range(99) < esc_pct)) begin
			send_word(ESCAPE_BYTE, 1'($urandom_range(1)));
			send_word(flipped, 1'($urandom_range(1)));
		end else
			send_word(value, 1'($urandom_range(1)));
	endtask

	// start, id, n_bytes of payload, then an optional checksum byte
	task automatic send_frame(input logic [7:0] id, input logic id_ready,
			input logic [55:0] payload, input trailer_t trailer, input int esc_pct,
			input int n_bytes);
		logic [15:0] total;
		logic [15:0] t;
		logic [7:0] check;
		total = '0;
		check = '0;
		send_word(START_BYTE, 1'($urandom_range(1)));
		send_word(id, id_ready);
		for (int i = 0; i < n_bytes; i++) begin
			send_stuffed(payload[8*i +: 8], esc_pct);
			total = total + 16'(payload[8*i +: 8]);
		end
		if (trailer != TRAILER_NONE) begin
			// search the byte that folds the sum to all ones
			for (int k = 0; k < 256; k++) begin
				t = total + 16'(k);
				if ({8'h00, t[7:0]} + {8'h00, t[15:8]} == SUM_GOOD)
					check = 8'(k);
			end
			if (trailer == TRAILER_BAD)
				check = check ^ 8'($urandom_range(1, 255));
			send_stuffed(check, esc_pct);
		end
	endtask

	// sender pauses until every result is back, block is idle afterwards
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_OWN_ID: cfg_own_id = value;
			REG_PEER_ID: cfg_peer_id = value;
			REG_CSUM_EN: cfg_csum_en = value[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return START_BYTE;
			1: return ESCAPE_BYTE;
			2: return 8'h00;
			3: return 8'hFF;
			4: return START_BYTE ^ ESCAPE_XOR;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// reset ids: hunting noise, slot with and without host ready, all-ones frame
	task automatic test_poll_and_frame();
		send_word(8'h55, 1'b1);
		send_word(START_BYTE, 1'b0);
		send_word(OWN_ID_RST, 1'b1);
		send_word(START_BYTE, 1'b1);
		send_word(OWN_ID_RST, 1'b0);
		send_word(8'hFF, 1'b1);
		// checksum of an all-ones payload comes out as all ones too
		send_frame(PEER_ID_RST, 1'b0, {56{1'b1}}, TRAILER_GOOD, 0, PAYLOAD_BYTES);
	endtask

	// both ids equal to the escape value, start byte in the id position
	task automatic test_id_corner_cases();
		drain_pipeline();
		write_reg(REG_OWN_ID, ESCAPE_BYTE);
		write_reg(REG_PEER_ID, ESCAPE_BYTE);
		send_word(START_BYTE, 1'b0);
		send_word(ESCAPE_BYTE, 1'b1);
		send_word(START_BYTE, 1'b1);
		// kind 0x81 makes the checksum byte a start value, so it goes out stuffed
		send_frame(ESCAPE_BYTE, 1'b0, {48'h0, 8'h81}, TRAILER_GOOD, 0, PAYLOAD_BYTES);
	endtask

	// start mid-frame and start right after an escape
	task automatic test_resync();
		logic [55:0] payload;
		for (int i = 0; i < PAYLOAD_BYTES; i++)
			payload[8*i +: 8] = pick_byte();
		drain_pipeline();
		write_reg(REG_OWN_ID, OWN_ID_RST);
		write_reg(REG_PEER_ID, PEER_ID_RST);
		send_frame(PEER_ID_RST, 1'b1, payload, TRAILER_NONE, 0, 3);
		send_word(ESCAPE_BYTE, 1'b1);
		send_frame(PEER_ID_RST, 1'b1, payload, TRAILER_GOOD, 30, PAYLOAD_BYTES);
	endtask

	// checksum switched off between payload bytes, ignored register index
	task automatic test_checksum_mode_switch();
		send_frame(PEER_ID_RST, 1'b0, 56'h0, TRAILER_NONE, 0, 3);
		drain_pipeline();
		write_reg(REG_CSUM_EN, 8'h00);
		write_reg(REG_UNUSED, 8'hFF);
		for (int i = 3; i < PAYLOAD_BYTES; i++)
			send_stuffed(8'(8'hA0 + i), 0);
		send_frame(PEER_ID_RST, 1'b1, 56'h0, TRAILER_NONE, 0, PAYLOAD_BYTES);
		send_word(8'h00, 1'b1);
	endtask

	// mostly well-formed frames and polls, some cut, corrupted or noise
	task automatic run_random_traffic(input int n_words);
		int stop_at;
		int next_reconfig;
		int r;
		logic [7:0] own;
		logic [7:0] peer;
		logic [55:0] payload;
		stop_at = words_sent + n_words;
		next_reconfig = words_sent;
		while (words_sent < stop_at) begin
			if (words_sent >= next_reconfig) begin
				drain_pipeline();
				case ($urandom_range(3))
					0: begin own = 8'h00; peer = 8'hFF; end
					1: begin own = 8'hFF; peer = 8'h00; end
					2: begin own = 8'($urandom_range(255)); peer = own; end
					default: begin
						own = 8'($urandom_range(255));
						peer = 8'($urandom_range(255));
					end
				endcase
				write_reg(REG_OWN_ID, own);
				write_reg(REG_PEER_ID, peer);
				// only bit 0 counts, upper data bits random
				write_reg(REG_CSUM_EN, 8'($urandom_range(255)));
				if ($urandom_range(3) == 0)
					write_reg(REG_UNUSED, 8'($urandom_range(255)));
				next_reconfig = words_sent + 60 + $urandom_range(40);
			end
			for (int i = 0; i < PAYLOAD_BYTES; i++)
				payload[8*i +: 8] = pick_byte();
			r = $urandom_range(99);
			if (r < 55)
				send_frame(cfg_peer_id, 1'($urandom_range(1)), payload,
					cfg_csum_en ? TRAILER_GOOD : TRAILER_NONE, 10, PAYLOAD_BYTES);
			else if (r < 68) begin
				send_word(START_BYTE, 1'($urandom_range(1)));
				send_word(cfg_own_id, 1'($urandom_range(1)));
			end else if (r < 78)
				send_frame(cfg_peer_id, 1'($urandom_range(1)), payload, TRAILER_BAD, 10,
					PAYLOAD_BYTES);
			else if (r < 88) begin
				// cut short, sometimes ending on an escape
				send_frame(cfg_peer_id, 1'($urandom_range(1)), payload, TRAILER_NONE, 10,
					$urandom_range(PAYLOAD_BYTES - 1));
				if ($urandom_range(1))
					send_word(ESCAPE_BYTE, 1'($urandom_range(1)));
			end else
				repeat ($urandom_range(1, 4))
					send_word(pick_byte(), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// sender idles rarely, receiver stalls often
		send_idle_pct = 6;
		recv_stall_pct = 63;
		test_poll_and_frame();
		test_id_corner_cases();
		test_resync();
		test_checksum_mode_switch();
		run_random_traffic(190);

		// the other way round
		send_idle_pct = 63;
		recv_stall_pct = 6;
		run_random_traffic(190);

		// full rate both sides
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random_traffic(190);

		s_tvalid <= 1'b0;
		for (int n = 0; n < 2000 && pending_results.size() != 0; n++)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", 64'(pending_results.size()), '0);

		$display("covered %0d line bytes, %0d results checked, %0d frames delivered",
			words_sent, results_checked, frames_predicted);
		$display("%0d transmit slots opened, %0d register writes, three stall mixes",
			slots_predicted, reg_writes);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// run limit, far above the slowest legal run
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

/* telemetry_poll_frame_receiver_core.f */
sv/tpfr_pkg.sv
sv/tpfr_byte_decoder.sv
sv/tpfr_frame_store.sv
sv/telemetry_poll_frame_receiver_core.sv
tb/telemetry_poll_frame_receiver_core_tb.sv
